// File: rtl/lapbdf_pkg.sv
package lapbdf_pkg;

  // Framing characters
  localparam logic [7:0] FLAG_CHAR = 8'h7E;  // '~'
  localparam logic [7:0] ESC_CHAR  = 8'h23;  // '#'

  // CRC-16-CCITT, MSB first, no final xor
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Frame layout
  localparam int MAX_DATA_DEF = 256;
  localparam int HEADER_LEN   = 3;
  localparam int DATA_OFS     = 5;  // header plus CRC trailer
  localparam int MIN_INNER    = 6;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Frame types
  localparam logic [1:0] FT_INFO  = 2'd0;
  localparam logic [1:0] FT_SUPER = 2'd1;
  localparam logic [1:0] FT_UNNUM = 2'd2;

  // Report status
  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_SHORT   = 2'd2;
  localparam logic [1:0] ST_LONG    = 2'd3;

  // Results pushed toward the output queue by one transaction
  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

  typedef logic [15:0] crc_tab_t [256];

  // Bitwise CRC step; used only to build the constant tables
  function automatic logic [15:0] crc_byte_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // T[a]: eight shifts of {a, 8'h00}
  function automatic crc_tab_t build_crc_tab();
    crc_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = crc_byte_step({8'(i), 8'h00}, 8'h00);
    end
    return t;
  endfunction

  localparam crc_tab_t CRC_TAB = build_crc_tab();

  // U[a] = T[T[a] high byte], feeds the two-byte update
  function automatic crc_tab_t build_crc_tab2();
    crc_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = CRC_TAB[CRC_TAB[i][15:8]];
    end
    return t;
  endfunction

  localparam crc_tab_t CRC_TAB2 = build_crc_tab2();

  // Advance the CRC by one byte
  function automatic logic [15:0] crc_one(logic [15:0] crc, logic [7:0] b);
    return {crc[7:0], 8'h00} ^ CRC_TAB[crc[15:8] ^ b];
  endfunction

  // Advance the CRC by two bytes with parallel lookups (b1 first)
  function automatic logic [15:0] crc_two(logic [15:0] crc, logic [7:0] b1,
                                          logic [7:0] b2);
    logic [7:0] a;
    a = crc[15:8] ^ b1;
    return CRC_TAB[crc[7:0] ^ b2] ^ CRC_TAB2[a] ^ {CRC_TAB[a][7:0], 8'h00};
  endfunction

endpackage

// File: rtl/lapbdf_deframe.sv
module lapbdf_deframe #(
  parameter int MAX_DATA = lapbdf_pkg::MAX_DATA_DEF,
  parameter int LEN_W    = $clog2(MAX_DATA + 1),
  parameter int RES_W    = 1 + 8 + 8 + 8 + 8 + 2 + LEN_W + 2 + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic [7:0]               rx_byte,
  output lapbdf_pkg::push_t        push,
  output logic [RES_W-1:0]         res0,
  output logic [RES_W-1:0]         res1
);

  localparam int CNT_W = $clog2(MAX_DATA + lapbdf_pkg::DATA_OFS + 1);
  localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(MAX_DATA + lapbdf_pkg::DATA_OFS);
  localparam logic [CNT_W-1:0] CNT_HDR  = CNT_W'(lapbdf_pkg::HEADER_LEN);
  localparam logic [CNT_W-1:0] CNT_OFS  = CNT_W'(lapbdf_pkg::DATA_OFS);
  localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(lapbdf_pkg::MIN_INNER);

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [2:0][7:0]  hdr;
    logic [1:0][7:0]  tr;
    logic             overlong;
  } frame_t;

  typedef struct packed {
    frame_t     st;
    logic       emit;
    logic [7:0] emit_byte;
  } inner_t;

  localparam frame_t FRAME_CLEAR = '0;

  // One unstuffed inner byte: fill header, or shift the trailer delay and emit
  function automatic inner_t inner_byte(frame_t s, logic [7:0] b);
    inner_t r;
    r.st        = s;
    r.emit      = 1'b0;
    r.emit_byte = s.tr[0];
    if (s.count < CNT_HDR) begin
      r.st.hdr[s.count[1:0]] = b;
    end else begin
      if (s.count >= CNT_OFS) begin
        if (s.count < CNT_SAT) begin
          r.emit = 1'b1;
        end else begin
          r.st.overlong = 1'b1;
        end
      end
      r.st.tr[0] = s.tr[1];
      r.st.tr[1] = b;
    end
    if (s.count < CNT_SAT) begin
      r.st.count = s.count + 1'b1;
    end
    return r;
  endfunction

  logic        in_frame, in_frame_next;
  logic        esc, esc_next;
  frame_t      frame, frame_next;
  logic [15:0] crc, crc_next;

  logic [7:0]  first_byte;
  inner_t      ia, ib;
  logic        use_a, use_b, report, clear;
  logic        e1, e2;
  logic [1:0]  ft;
  logic [1:0]  st;
  logic [LEN_W-1:0] len;
  logic [RES_W-1:0] rep_res;

  always_comb begin
    first_byte = rx_byte;
    if (esc) begin
      first_byte = (rx_byte == lapbdf_pkg::FLAG_CHAR) ? lapbdf_pkg::FLAG_CHAR
                                                      : lapbdf_pkg::ESC_CHAR;
    end
    ia = inner_byte(frame, first_byte);
    ib = inner_byte(ia.st, rx_byte);
  end

  // Decode the byte against the framing state
  always_comb begin
    in_frame_next = in_frame;
    esc_next      = esc;
    use_a         = 1'b0;
    use_b         = 1'b0;
    report        = 1'b0;
    clear         = 1'b0;
    priority if (!in_frame) begin
      if (rx_byte == lapbdf_pkg::FLAG_CHAR) begin
        in_frame_next = 1'b1;
        clear         = 1'b1;
      end
    end else if (esc) begin
      esc_next = 1'b0;
      use_a    = 1'b1;
      if (rx_byte == lapbdf_pkg::ESC_CHAR) begin
        esc_next = 1'b1;
      end else if (rx_byte != lapbdf_pkg::FLAG_CHAR) begin
        use_b = 1'b1;
      end
    end else if (rx_byte == lapbdf_pkg::FLAG_CHAR) begin
      clear = 1'b1;
      if (frame.count != '0) begin
        report        = 1'b1;
        in_frame_next = 1'b0;
      end
    end else if (rx_byte == lapbdf_pkg::ESC_CHAR) begin
      esc_next = 1'b1;
    end else begin
      use_a = 1'b1;
    end
  end

  assign e1 = use_a & ia.emit;
  assign e2 = use_b & ib.emit;

  always_comb begin
    frame_next = frame;
    if (use_b) begin
      frame_next = ib.st;
    end else if (use_a) begin
      frame_next = ia.st;
    end
    if (clear) begin
      frame_next = FRAME_CLEAR;
    end
  end

  always_comb begin
    crc_next = crc;
    priority if (clear) begin
      crc_next = lapbdf_pkg::CRC_INIT;
    end else if (e1 && e2) begin
      crc_next = lapbdf_pkg::crc_two(crc, ia.emit_byte, ib.emit_byte);
    end else if (e1) begin
      crc_next = lapbdf_pkg::crc_one(crc, ia.emit_byte);
    end else if (e2) begin
      crc_next = lapbdf_pkg::crc_one(crc, ib.emit_byte);
    end
  end

  // End-of-frame report
  always_comb begin
    unique case (frame.hdr[1][7:6])
      2'd3:    ft = lapbdf_pkg::FT_UNNUM;
      2'd2:    ft = lapbdf_pkg::FT_SUPER;
      default: ft = lapbdf_pkg::FT_INFO;
    endcase
    len = '0;
    priority if (frame.count < CNT_MIN) begin
      st = lapbdf_pkg::ST_SHORT;
    end else if (frame.overlong) begin
      st  = lapbdf_pkg::ST_LONG;
      len = LEN_W'(frame.count - CNT_OFS);
    end else begin
      st  = ({frame.tr[1], frame.tr[0]} == crc) ? lapbdf_pkg::ST_GOOD
                                                : lapbdf_pkg::ST_CRC_ERR;
      len = LEN_W'(frame.count - CNT_OFS);
    end
    rep_res = {lapbdf_pkg::KIND_REPORT, 8'h00, frame.hdr[0], frame.hdr[1],
               frame.hdr[2], ft, len, st, 1'b1};
  end

  // Results of this transaction, in order
  always_comb begin
    push.push0 = take & (e1 | e2 | report);
    push.push1 = take & e1 & e2;
    res1 = {lapbdf_pkg::KIND_DATA, ib.emit_byte, 24'h0, 2'b00, {LEN_W{1'b0}},
            2'b00, 1'b1};
    priority if (e1) begin
      res0 = {lapbdf_pkg::KIND_DATA, ia.emit_byte, 24'h0, 2'b00, {LEN_W{1'b0}},
              2'b00, ~e2};
    end else if (e2) begin
      res0 = res1;
    end else begin
      res0 = rep_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      esc      <= 1'b0;
      frame    <= FRAME_CLEAR;
      crc      <= lapbdf_pkg::CRC_INIT;
    end else if (take) begin
      in_frame <= in_frame_next;
      esc      <= esc_next;
      frame    <= frame_next;
      crc      <= crc_next;
    end
  end

endmodule

// File: rtl/lapb_frame_deframer_crc_check_top.sv
// LAPB/HDLC-style byte deframer with CRC-16-CCITT check. Raw line bytes go
// in on rx_byte, one transaction per byte; '~' opens a frame, "#~" stands
// for a literal '~', and a closing '~' produces an end-of-frame report with
// the address and control bytes, frame type, payload length and status.
// Payload bytes come out (kind 0) two inner bytes late so the CRC trailer is
// never shown. Each byte is decoded in the cycle it is accepted, so one byte
// is taken per cycle while in_ready is high; results land in a four-entry
// output queue that drains one result per cycle while out_ready is high,
// and in_ready drops at three or more queued results. An ordinary byte
// after a "#" can yield two payload results, so the sustained rate is capped
// by the output port at one result per cycle. No clearing pass after reset.
module lapb_frame_deframer_crc_check_top #(
  parameter int MAX_DATA = lapbdf_pkg::MAX_DATA_DEF,
  parameter int LEN_W    = $clog2(MAX_DATA + 1)
) (
  input  logic             clk,
  input  logic             rst,
  // input channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       rx_byte,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic             kind,
  output logic [7:0]       data_byte,
  output logic [7:0]       address_byte,
  output logic [7:0]       control_first,
  output logic [7:0]       control_second,
  output logic [1:0]       frame_type,
  output logic [LEN_W-1:0] data_length,
  output logic [1:0]       status,
  output logic             last
);

  localparam int RES_W = 1 + 8 + 8 + 8 + 8 + 2 + LEN_W + 2 + 1;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  logic                take;
  lapbdf_pkg::push_t   push;
  logic [RES_W-1:0]    res0, res1;

  logic [RES_W-1:0]    q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     q_count, q_count_next;
  logic                pop;

  // Accept a byte only when the queue has room for its worst case of two
  assign in_ready = (q_count <= (QPTR_W + 1)'(QDEPTH - 2));
  assign take     = in_valid & in_ready;

  lapbdf_deframe #(
    .MAX_DATA (MAX_DATA),
    .LEN_W    (LEN_W),
    .RES_W    (RES_W)
  ) u_deframe (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .push    (push),
    .res0    (res0),
    .res1    (res1)
  );

  assign out_valid = (q_count != '0);
  assign pop       = out_valid & out_ready;

  always_comb begin
    wr_ptr_next  = wr_ptr + QPTR_W'(push.push0) + QPTR_W'(push.push1);
    q_count_next = q_count + (QPTR_W + 1)'(push.push0) + (QPTR_W + 1)'(push.push1)
                   - (QPTR_W + 1)'(pop);
  end

  // Control pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr_next;
      q_count <= q_count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Queue storage; second result goes into the slot after the first
  always_ff @(posedge clk) begin
    if (push.push0) begin
      q_mem[wr_ptr] <= res0;
    end
    if (push.push1) begin
      q_mem[wr_ptr + 1'b1] <= res1;
    end
  end

  // Head of the queue drives the result fields
  assign {kind, data_byte, address_byte, control_first, control_second,
          frame_type, data_length, status, last} = q_mem[rd_ptr];

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= (QPTR_W + 1)'(QDEPTH))
    else $error("output queue overflow");

  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push.push1 |-> push.push0)
    else $error("second result pushed without the first");

  a_push_needs_take: assert property (@(posedge clk) disable iff (rst)
    push.push0 |-> take)
    else $error("result pushed without an accepted transaction");

  a_report_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == lapbdf_pkg::KIND_REPORT) |-> last)
    else $error("end-of-frame report not marked last");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == lapbdf_pkg::KIND_DATA) |->
      (address_byte == 8'h00 && status == lapbdf_pkg::ST_GOOD &&
       data_length == '0))
    else $error("payload result carries report fields");
`endif

endmodule

// File: bench/lapb_deframe_checker.sv
`timescale 1ns / 1ps
module lapb_deframe_checker #(
  parameter int MAX_DATA = lapbdf_pkg::MAX_DATA_DEF,
  parameter int LEN_W    = $clog2(MAX_DATA + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       rx_byte,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             kind,
  input  logic [7:0]       data_byte,
  input  logic [7:0]       address_byte,
  input  logic [7:0]       control_first,
  input  logic [7:0]       control_second,
  input  logic [1:0]       frame_type,
  input  logic [LEN_W-1:0] data_length,
  input  logic [1:0]       status,
  input  logic             last,
  output int               fail_count,
  output int               outstanding,
  output int               checked
);

  typedef struct packed {
    logic             kind;
    logic [7:0]       data;
    logic [7:0]       addr;
    logic [7:0]       ctl0;
    logic [7:0]       ctl1;
    logic [1:0]       ftype;
    logic [LEN_W-1:0] len;
    logic [1:0]       stat;
    logic             fin;
  } frame_result_t;

  frame_result_t pending_results[$];

  // Deframer state as seen from the line
  logic        open_frame;
  logic        hash_held;
  logic        too_long;
  int          inner_len;
  logic [7:0]  hdr [3];
  logic [7:0]  lag [2];
  logic [15:0] crc_run;
  int          fails;
  int          compared;

  // CRC-16-CCITT, MSB first
  function automatic logic [15:0] crc16_next(logic [15:0] acc, logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ lapbdf_pkg::CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic string show(frame_result_t r);
    return $sformatf({"kind=%0d data=%02h adr=%02h ctl=%02h/%02h type=%0d",
                      " len=%0d st=%0d last=%0d"},
                     r.kind, r.data, r.addr, r.ctl0, r.ctl1, r.ftype, r.len, r.stat,
                     r.fin);
  endfunction

  task automatic restart_frame();
    hash_held = 1'b0;
    too_long  = 1'b0;
    inner_len = 0;
    hdr       = '{8'h00, 8'h00, 8'h00};
    lag       = '{8'h00, 8'h00};
    crc_run   = lapbdf_pkg::CRC_INIT;
  endtask

  // Shift one unstuffed byte in: header first, then release payload two bytes late
  task automatic take_inner(input logic [7:0] b, inout int n);
    frame_result_t r;
    if (inner_len < lapbdf_pkg::HEADER_LEN) begin
      hdr[inner_len] = b;
    end else begin
      if (inner_len >= lapbdf_pkg::DATA_OFS) begin
        if (inner_len - lapbdf_pkg::DATA_OFS < MAX_DATA) begin
          r      = '0;
          r.kind = lapbdf_pkg::KIND_DATA;
          r.data = lag[0];
          pending_results.push_back(r);
          n++;
          crc_run = crc16_next(crc_run, lag[0]);
        end else begin
          too_long = 1'b1;
        end
      end
      lag[0] = lag[1];
      lag[1] = b;
    end
    if (inner_len < MAX_DATA + lapbdf_pkg::DATA_OFS) inner_len++;
  endtask

  task automatic report_frame(inout int n);
    frame_result_t r;
    r      = '0;
    r.kind = lapbdf_pkg::KIND_REPORT;
    r.addr = hdr[0];
    r.ctl0 = hdr[1];
    r.ctl1 = hdr[2];
    unique case (hdr[1][7:6])
      2'b10:   r.ftype = lapbdf_pkg::FT_SUPER;
      2'b11:   r.ftype = lapbdf_pkg::FT_UNNUM;
      default: r.ftype = lapbdf_pkg::FT_INFO;
    endcase
    if (inner_len < lapbdf_pkg::MIN_INNER) begin
      r.stat = lapbdf_pkg::ST_SHORT;
    end else begin
      r.len = LEN_W'(inner_len - lapbdf_pkg::DATA_OFS);
      if (too_long) r.stat = lapbdf_pkg::ST_LONG;
      else r.stat = ({lag[1], lag[0]} == crc_run) ? lapbdf_pkg::ST_GOOD
                                                 : lapbdf_pkg::ST_CRC_ERR;
    end
    pending_results.push_back(r);
    n++;
    open_frame = 1'b0;
    restart_frame();
  endtask

  // Expected results of one accepted line byte
  task automatic deframe_byte(input logic [7:0] b);
    int n = 0;
    if (!open_frame) begin
      if (b == lapbdf_pkg::FLAG_CHAR) begin
        open_frame = 1'b1;
        restart_frame();
      end
    end else if (hash_held) begin
      hash_held = 1'b0;
      if (b == lapbdf_pkg::FLAG_CHAR) begin
        take_inner(lapbdf_pkg::FLAG_CHAR, n);
      end else begin
        take_inner(lapbdf_pkg::ESC_CHAR, n);
        if (b == lapbdf_pkg::ESC_CHAR) hash_held = 1'b1;
        else take_inner(b, n);
      end
    end else if (b == lapbdf_pkg::FLAG_CHAR) begin
      if (inner_len == 0) restart_frame();
      else report_frame(n);
    end else if (b == lapbdf_pkg::ESC_CHAR) begin
      hash_held = 1'b1;
    end else begin
      take_inner(b, n);
    end
    if (n > 0) pending_results[pending_results.size() - 1].fin = 1'b1;
  endtask

  always @(posedge clk) begin : watch
    frame_result_t got;
    frame_result_t want;
    if (rst) begin
      open_frame = 1'b0;
      restart_frame();
      pending_results.delete();
    end else begin
      if (in_valid && in_ready) deframe_byte(rx_byte);
      if (out_valid && out_ready) begin
        got = {kind, data_byte, address_byte, control_first, control_second,
               frame_type, data_length, status, last};
        if (pending_results.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result at %0t: %s", $realtime, show(got));
        end else begin
          want = pending_results.pop_front();
          compared++;
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("result %0d mismatch at %0t", compared, $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
    end
    fail_count  <= fails;
    outstanding <= pending_results.size();
    checked     <= compared;
  end

endmodule

// File: bench/lapb_frame_deframer_crc_check_top_test.sv
`timescale 1ns / 1ps
module lapb_frame_deframer_crc_check_top_test;

  localparam int MAX_DATA     = lapbdf_pkg::MAX_DATA_DEF;
  localparam int LEN_W        = $clog2(MAX_DATA + 1);
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 150;
  localparam int BURST_DATA   = 40;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 20;

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       rx_byte = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             kind;
  logic [7:0]       data_byte;
  logic [7:0]       address_byte;
  logic [7:0]       control_first;
  logic [7:0]       control_second;
  logic [1:0]       frame_type;
  logic [LEN_W-1:0] data_length;
  logic [1:0]       status;
  logic             last;

  int fail_count;
  int outstanding;
  int checked;

  // Stimulus bookkeeping
  int         cycles = 0;
  int         sent_bytes = 0;
  int         noise_bytes = 0;
  int         frames_sent = 0;
  int         crc_broken = 0;
  int         hold_requests = 0;
  int         holds_done = 0;
  bit         tx_burst = 1'b0;
  bit         rx_burst = 1'b0;
  int         pick;
  int         n;
  logic [7:0] payload[$];

  lapb_frame_deframer_crc_check_top #(.MAX_DATA(MAX_DATA)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .data_byte      (data_byte),
    .address_byte   (address_byte),
    .control_first  (control_first),
    .control_second (control_second),
    .frame_type     (frame_type),
    .data_length    (data_length),
    .status         (status),
    .last           (last)
  );

  // Watch both channels, predict every result and count mismatches
  lapb_deframe_checker #(.MAX_DATA(MAX_DATA)) chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .data_byte      (data_byte),
    .address_byte   (address_byte),
    .control_first  (control_first),
    .control_second (control_second),
    .frame_type     (frame_type),
    .data_length    (data_length),
    .status         (status),
    .last           (last),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .checked        (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: give up once the cycle budget is spent
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timed out after %0d cycles with %0d results still due", cycles, outstanding);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one line byte and hold it until the transaction completes.
  // Drive on the falling edge, sample the handshake on the rising edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
  endtask

  // Stuff a literal flag inside a frame as escape plus flag
  task automatic put_inner(input logic [7:0] b);
    if (b == lapbdf_pkg::FLAG_CHAR) send_byte(lapbdf_pkg::ESC_CHAR);
    send_byte(b);
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Bias toward the framing characters so escapes show up often
  function automatic logic [7:0] line_byte();
    case ($urandom_range(0, 7))
      0:       return lapbdf_pkg::FLAG_CHAR;
      1:       return lapbdf_pkg::ESC_CHAR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic fill_payload(input int len);
    payload.delete();
    repeat (len) payload.push_back(line_byte());
  endtask

  // Send a full frame around the current payload; optionally break its CRC
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] c0,
                            input logic [7:0] c1, input bit corrupt);
    logic [15:0] fcs;
    fcs = lapbdf_pkg::CRC_INIT;
    send_byte(lapbdf_pkg::FLAG_CHAR);
    put_inner(addr);
    put_inner(c0);
    put_inner(c1);
    foreach (payload[i]) begin
      put_inner(payload[i]);
      fcs ^= {payload[i], 8'h00};
      for (int k = 0; k < 8; k++) begin
        fcs = fcs[15] ? ({fcs[14:0], 1'b0} ^ lapbdf_pkg::CRC_POLY) : {fcs[14:0], 1'b0};
      end
    end
    if (corrupt) begin
      fcs ^= 16'h0001 << $urandom_range(0, 15);
      crc_broken++;
    end
    put_inner(fcs[7:0]);
    put_inner(fcs[15:8]);
    send_byte(lapbdf_pkg::FLAG_CHAR);
    frames_sent++;
  endtask

  // Drop valid and hold off until every predicted result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Result sink: random stall per transaction, stretches with none, and a
  // long hold-off whenever the stimulus asks for one
  initial begin : result_sink
    int stall;
    while (rst) @(negedge clk);
    forever begin
      if (holds_done < hold_requests) begin
        holds_done++;
        stall = LONG_HOLD;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      @(negedge clk);
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: idle noise with a hash, a frame holding only the address,
    // a resync flag, escapes with a hash pair ahead of a plain byte (two
    // payload results from one byte), then a frame with a broken CRC.
    send_byte(lapbdf_pkg::ESC_CHAR);
    send_byte(lapbdf_pkg::FLAG_CHAR);
    send_byte(8'h80);
    send_byte(lapbdf_pkg::FLAG_CHAR);
    send_byte(lapbdf_pkg::FLAG_CHAR);
    payload = '{lapbdf_pkg::FLAG_CHAR, lapbdf_pkg::ESC_CHAR, lapbdf_pkg::ESC_CHAR,
                8'h41, 8'h00, 8'hFF};
    send_frame(8'hFF, 8'hC3, 8'h00, 1'b0);
    payload = '{8'h5A};
    send_frame(8'h00, 8'h40, 8'h7F, 1'b1);
    wait_drained();

    // Random: mostly well-formed random frames, the rest broken-CRC frames,
    // short frames, line noise and frames with stray flags and escapes
    while (sent_bytes - noise_bytes < RANDOM_BYTES) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        fill_payload($urandom_range(0, 16));
        send_frame(rand_byte(), rand_byte(), rand_byte(), 1'b0);
      end else if (pick < 80) begin
        fill_payload($urandom_range(1, 8));
        send_frame(rand_byte(), rand_byte(), rand_byte(), 1'b1);
      end else if (pick < 88) begin
        send_byte(lapbdf_pkg::FLAG_CHAR);
        repeat ($urandom_range(0, 5)) put_inner(rand_byte());
        send_byte(lapbdf_pkg::FLAG_CHAR);
      end else if (pick < 94) begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(rand_byte());
        noise_bytes += n;
      end else begin
        send_byte(lapbdf_pkg::FLAG_CHAR);
        repeat ($urandom_range(1, 12)) send_byte(line_byte());
        send_byte(lapbdf_pkg::FLAG_CHAR);
      end
      // Now and then pause the line until the output side is empty
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
    wait_drained();

    // Back-to-back frame while the sink holds off, so the output queue
    // fills and the input side stalls
    hold_requests++;
    tx_burst = 1'b1;
    fill_payload(BURST_DATA);
    send_frame(rand_byte(), rand_byte(), rand_byte(), 1'b0);
    tx_burst = 1'b0;
    wait_drained();

    // Overlong frame: length saturates and the status flags it
    fill_payload(MAX_DATA + 12);
    send_frame(rand_byte(), rand_byte(), rand_byte(), 1'b0);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("line bytes sent: %0d in %0d frames (%0d with a corrupted CRC), noise %0d",
             sent_bytes, frames_sent, crc_broken, noise_bytes);
    $display("results compared: %0d, long output hold-offs: %0d, mismatches: %0d",
             checked, holds_done, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/lapbdf_pkg.sv
rtl/lapbdf_deframe.sv
rtl/lapb_frame_deframer_crc_check_top.sv
bench/lapb_deframe_checker.sv
bench/lapb_frame_deframer_crc_check_top_test.sv
